[hdl/assert_macros.svh]
// Assertion macros for the checker file, sukt_chk.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is asserted.
`define SUKT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sukt assertion failed");

// Concurrent check that also runs through reset.
`define SUKT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sukt assertion failed during reset");

`endif

[hdl/sukt_pkg.sv]
// Shared types and constants for the sorted unique key table.
// No dependencies.
package sukt_pkg;

  localparam int DEPTH = 16;
  localparam int KW    = 32;
  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_SEARCH = 2'd2,
    FN_DUMP   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DECIDE,
    S_INS_RD,
    S_INS_WR,
    S_PUT,
    S_DEL_RD,
    S_DEL_WR,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic          re;
    logic [IW-1:0] raddr;
    logic          we;
    logic [IW-1:0] waddr;
    logic [KW-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    status_t       status;
    logic [KW-1:0] key;
    logic [CW-1:0] count;
    logic          last;
  } res_t;

endpackage

[hdl/sukt_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module sukt_ram #(
  parameter int Depth = 16,
  parameter int Width = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/sukt_ctrl.sv]
// Sequencer for the key table: scan, shift, dump and result generation.
// Depends on sukt_pkg; drives the key RAM through a mem_req_t struct.
module sukt_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_func,
  input  logic [sukt_pkg::KW-1:0] in_key,
  output sukt_pkg::mem_req_t      mem_req,
  input  logic [sukt_pkg::KW-1:0] mem_rdata,
  output logic                    res_valid,
  input  logic                    res_ready,
  output sukt_pkg::res_t          res
);
  import sukt_pkg::*;

  state_t        state_r, state_nxt;
  func_t         func_r, func_nxt;
  logic [KW-1:0] key_r, key_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          hit_r, hit_nxt;
  status_t       rstat_r, rstat_nxt;
  logic [KW-1:0] rkey_r, rkey_nxt;

  logic [CW-1:0] idx_inc, idx_dec, pos_inc;
  logic          accept;
  logic          dump_last;

  assign idx_inc   = idx_r + CW'(1);
  assign idx_dec   = idx_r - CW'(1);
  assign pos_inc   = pos_r + CW'(1);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign dump_last = (idx_inc == count_r);

  // next state and register updates
  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    key_nxt   = key_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    hit_nxt   = hit_r;
    rstat_nxt = rstat_r;
    rkey_nxt  = rkey_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt = func_t'(in_func);
          key_nxt  = in_key;
          idx_nxt  = '0;
          pos_nxt  = '0;
          hit_nxt  = 1'b0;
          if (func_t'(in_func) == FN_DUMP) begin
            if (count_r == '0) begin
              rstat_nxt = ST_EMPTY;
              rkey_nxt  = '0;
              state_nxt = S_RESULT;
            end else begin
              state_nxt = S_DUMP_RD;
            end
          end else if (count_r == '0) begin
            state_nxt = S_DECIDE;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if ($signed(mem_rdata) < $signed(key_r)) begin
          idx_nxt = idx_inc;
          if (idx_inc == count_r) begin
            pos_nxt   = count_r;
            hit_nxt   = 1'b0;
            state_nxt = S_DECIDE;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end else begin
          pos_nxt   = idx_r;
          hit_nxt   = (mem_rdata == key_r);
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        rkey_nxt = key_r;
        if (func_r == FN_INSERT) begin
          if (hit_r) begin
            rstat_nxt = ST_DUP;
            state_nxt = S_RESULT;
          end else if (count_r == CW'(DEPTH)) begin
            rstat_nxt = ST_FULL;
            state_nxt = S_RESULT;
          end else if (pos_r == count_r) begin
            state_nxt = S_PUT;
          end else begin
            idx_nxt   = count_r - CW'(1);
            state_nxt = S_INS_RD;
          end
        end else if (count_r == '0) begin
          rstat_nxt = ST_EMPTY;
          state_nxt = S_RESULT;
        end else if (!hit_r) begin
          rstat_nxt = ST_NOTFOUND;
          state_nxt = S_RESULT;
        end else if (func_r == FN_DELETE) begin
          rstat_nxt = ST_OK;
          if (pos_inc == count_r) begin
            count_nxt = count_r - CW'(1);
            state_nxt = S_RESULT;
          end else begin
            idx_nxt   = pos_inc;
            state_nxt = S_DEL_RD;
          end
        end else begin
          // search hit: stored key equals the probe
          rstat_nxt = ST_OK;
          state_nxt = S_RESULT;
        end
      end
      S_INS_RD: begin
        state_nxt = S_INS_WR;
      end
      S_INS_WR: begin
        if (idx_r == pos_r) begin
          state_nxt = S_PUT;
        end else begin
          idx_nxt   = idx_dec;
          state_nxt = S_INS_RD;
        end
      end
      S_PUT: begin
        count_nxt = count_r + CW'(1);
        rstat_nxt = ST_OK;
        state_nxt = S_RESULT;
      end
      S_DEL_RD: begin
        state_nxt = S_DEL_WR;
      end
      S_DEL_WR: begin
        if (idx_inc == count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_RESULT;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_DEL_RD;
        end
      end
      S_DUMP_RD: begin
        state_nxt = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        if (res_ready) begin
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_DUMP_RD;
          end
        end
      end
      S_RESULT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    mem_req       = '0;
    mem_req.raddr = idx_r[IW-1:0];
    mem_req.waddr = idx_r[IW-1:0];
    mem_req.wdata = mem_rdata;
    in_stall      = (state_r != S_IDLE);
    res_valid     = 1'b0;
    res.status    = rstat_r;
    res.key       = rkey_r;
    res.count     = count_r;
    res.last      = 1'b1;
    case (state_r)
      S_SCAN_RD, S_INS_RD, S_DEL_RD, S_DUMP_RD: begin
        mem_req.re = 1'b1;
      end
      S_INS_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_inc[IW-1:0];
      end
      S_DEL_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_dec[IW-1:0];
      end
      S_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_r[IW-1:0];
        mem_req.wdata = key_r;
      end
      S_DUMP_OUT: begin
        res_valid  = 1'b1;
        res.status = ST_OK;
        res.key    = mem_rdata;
        res.last   = dump_last;
      end
      S_RESULT: begin
        res_valid = 1'b1;
      end
      default: begin
        mem_req.re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    key_r   <= key_nxt;
    idx_r   <= idx_nxt;
    pos_r   <= pos_nxt;
    hit_r   <= hit_nxt;
    rstat_r <= rstat_nxt;
    rkey_r  <= rkey_nxt;
  end

endmodule

[hdl/sorted_unique_key_table_unit.sv]
// Sorted unique key table: one key RAM, a sequencer and the output register.
// Search, delete and insert first scan the stored keys in order (none on an empty
// table); a delete that hits and an insert that stores its key then shift the
// keys behind the position, and the insert writes its key in a final step. A
// dump reads and presents each stored key in turn. Every result can be held by
// an output stall. The key RAM has a single registered read port: each scan
// step and each shift step is a read followed by a compare or write. One item
// is worked at a time; a new word is taken once the previous item's last result
// has been handed to the output register.
module sorted_unique_key_table_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_func,
  input  logic [sukt_pkg::KW-1:0] in_key,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              out_status,
  output logic [sukt_pkg::KW-1:0] out_key_out,
  output logic [sukt_pkg::CW-1:0] out_count_out,
  output logic                    out_last
);
  import sukt_pkg::*;

  mem_req_t      mem_req;
  logic [KW-1:0] mem_rdata;
  logic          res_valid;
  logic          res_ready;
  res_t          res;

  logic          out_valid_r, out_valid_nxt;
  res_t          out_r;

  sukt_ram #(
    .Depth(DEPTH),
    .Width(KW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_req.we),
    .waddr(mem_req.waddr),
    .wdata(mem_req.wdata),
    .re   (mem_req.re),
    .raddr(mem_req.raddr),
    .rdata(mem_rdata)
  );

  sukt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_func  (in_func),
    .in_key   (in_key),
    .mem_req  (mem_req),
    .mem_rdata(mem_rdata),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // output register frees when empty or its word is taken this cycle
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_r.status;
  assign out_key_out   = out_r.key;
  assign out_count_out = out_r.count;
  assign out_last      = out_r.last;

endmodule

[hdl/sukt_chk.sv]
// Port-level checker for the sorted unique key table, bound to the top level.
// Depends on sukt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sukt_chk (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic [1:0]              in_func,
  input logic [sukt_pkg::KW-1:0] in_key,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [2:0]              out_status,
  input logic [sukt_pkg::KW-1:0] out_key_out,
  input logic [sukt_pkg::CW-1:0] out_count_out,
  input logic                    out_last
);
  import sukt_pkg::*;

  logic [KW+1:0]    in_word;
  logic [KW+CW+3:0] out_word;
  assign in_word  = {in_func, in_key};
  assign out_word = {out_status, out_key_out, out_count_out, out_last};

  // a stalled result word holds
  `SUKT_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_word))
  // the table never reports more keys than it holds
  `SUKT_ASSERT(a_count_max, clk, rst_n, out_valid |-> out_count_out <= CW'(DEPTH))
  // any non-ok status ends its item
  `SUKT_ASSERT(a_err_last, clk, rst_n, out_valid && out_status != ST_OK |-> out_last)
  // an accepted word makes the block busy on the next cycle
  `SUKT_ASSERT(a_busy, clk, rst_n, in_valid && !in_stall |=> in_stall && $stable(in_word) || in_stall)
  // no result leaves right after reset
  `SUKT_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid)

endmodule

bind sorted_unique_key_table_unit sukt_chk u_chk (.*);
